// ----- rtl/kntd_pkg.sv -----
// Package for the keyed nibble text decipher: payload types, phase codes, key ROM and helpers.
`timescale 1ns / 1ps

package kntd_pkg;

    typedef struct packed {
        logic [7:0] cipher_char;
        logic       first;
    } t_in;

    typedef struct packed {
        logic [7:0] plain_byte;
        logic       last;
    } t_out;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_START_L = 3'd1,
        PH_LEN0_H  = 3'd2,
        PH_LEN0_L  = 3'd3,
        PH_LEN1_H  = 3'd4,
        PH_LEN1_L  = 3'd5,
        PH_DATA_H  = 3'd6,
        PH_DATA_L  = 3'd7
    } t_phase;

    localparam int KEY_DEPTH = 256;

    // Key ROM: the ASCII codes of a 256-character hex text, entry 0 in the top byte.
    localparam logic [8*KEY_DEPTH-1:0] KEY_TEXT = {
        "0dc43e4ae9f86c17c4744ac5d94ebe8fcb8b6341916915155be5db4d2e991e20",
        "3a5510a0c4c9e4be40038b9ae1c88ffda6b04bf5ba6c74d1fc9f307d2d1f97fd",
        "682b5e46fdbaed95c526bb245cf1f25a5c39a044b7a732deebcc24153be35415",
        "843d41036c4555bc6061be4c46f94f3aa5a2bc374ecd75ab46cb2ee22ecafe28"
    };

    localparam logic [7:0] CHAR_LA   = 8'h61;
    localparam logic [7:0] CHAR_LF   = 8'h66;
    localparam logic [7:0] CHAR_UA   = 8'h41;
    localparam logic [7:0] CHAR_UF   = 8'h46;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] HEX_TEN   = 8'd10;

    function automatic logic [7:0] key_byte(input logic [7:0] idx);
        logic [7:0] rev;
        rev = 8'(KEY_DEPTH - 1) - idx;
        return KEY_TEXT[{rev, 3'b000} +: 8];
    endfunction

    function automatic logic [7:0] digit_value(input logic [7:0] c);
        logic [7:0] v;
        if (c >= CHAR_LA && c <= CHAR_LF) begin
            v = c - CHAR_LA + HEX_TEN;
        end else if (c >= CHAR_UA && c <= CHAR_UF) begin
            v = c - CHAR_UA + HEX_TEN;
        end else begin
            v = c - CHAR_ZERO;
        end
        return v;
    endfunction

    // Two-digit value wraps modulo 256, so only the low nibble of the high digit counts.
    function automatic logic [7:0] hex_pair(input logic [7:0] hi, input logic [7:0] lo);
        logic [7:0] dh;
        dh = digit_value(hi);
        return {dh[3:0], 4'b0000} + digit_value(lo);
    endfunction

    function automatic logic [3:0] letter_nibble(input logic [7:0] c);
        logic [7:0] d;
        d = c - CHAR_LA;
        return d[3:0];
    endfunction

endpackage

// ----- rtl/keyed_nibble_text_decipher.sv -----
// Top level of the keyed nibble text decipher: phase control, key XOR and output register.
// A plaintext byte is loaded into the output register in the cycle after its second
// character is transferred in. Throughput: one character per cycle while the input is not stalled.
// The input stalls only while a result waits in the output register and the sink stalls.
// Reset (synchronous, active low) clears the output valid and puts the decoder idle,
// ignoring characters until one arrives with first set.
`timescale 1ns / 1ps

module keyed_nibble_text_decipher
    import kntd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out
);

    t_phase     r_phase, n_phase;
    logic [7:0] r_key_pos, n_key_pos;
    logic [7:0] r_high_hold, n_high_hold;
    logic [7:0] r_len_hold, n_len_hold;
    logic [3:0] r_pending, n_pending;
    logic [7:0] r_remaining, n_remaining;
    logic       r_out_valid, n_out_valid;
    t_out       r_out, n_out;

    logic       in_fire;
    logic       res_valid;
    logic [7:0] pair_byte;
    logic [7:0] rem_dec;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_fire     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign pair_byte = {r_pending, letter_nibble(i_in.cipher_char)} ^ key_byte(r_key_pos);
    assign rem_dec   = r_remaining - 8'd1;

    always_comb begin
        n_phase     = r_phase;
        n_key_pos   = r_key_pos;
        n_high_hold = r_high_hold;
        n_len_hold  = r_len_hold;
        n_pending   = r_pending;
        n_remaining = r_remaining;
        res_valid   = 1'b0;
        n_out       = r_out;
        if (in_fire) begin
            if (i_in.first) begin
                n_high_hold = i_in.cipher_char;
                n_phase     = PH_START_L;
            end else begin
                unique case (r_phase)
                    PH_IDLE: begin
                    end
                    PH_START_L: begin
                        n_key_pos = hex_pair(r_high_hold, i_in.cipher_char);
                        n_phase   = PH_LEN0_H;
                    end
                    PH_LEN0_H: begin
                        n_pending = letter_nibble(i_in.cipher_char);
                        n_phase   = PH_LEN0_L;
                    end
                    PH_LEN0_L: begin
                        n_len_hold = pair_byte;
                        n_key_pos  = r_key_pos + 8'd1;
                        n_phase    = PH_LEN1_H;
                    end
                    PH_LEN1_H: begin
                        n_pending = letter_nibble(i_in.cipher_char);
                        n_phase   = PH_LEN1_L;
                    end
                    PH_LEN1_L: begin
                        n_remaining = hex_pair(r_len_hold, pair_byte);
                        n_key_pos   = r_key_pos + 8'd1;
                        n_phase     = (n_remaining == 8'd0) ? PH_IDLE : PH_DATA_H;
                    end
                    PH_DATA_H: begin
                        n_pending = letter_nibble(i_in.cipher_char);
                        n_phase   = PH_DATA_L;
                    end
                    PH_DATA_L: begin
                        n_remaining      = rem_dec;
                        n_key_pos        = r_key_pos + 8'd1;
                        n_phase          = (rem_dec == 8'd0) ? PH_IDLE : PH_DATA_H;
                        res_valid        = 1'b1;
                        n_out.plain_byte = pair_byte;
                        n_out.last       = (rem_dec == 8'd0);
                    end
                endcase
            end
        end
        // Load a new result, or drop the old one once the sink takes it.
        if (res_valid) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key_pos   <= n_key_pos;
        r_high_hold <= n_high_hold;
        r_len_hold  <= n_len_hold;
        r_pending   <= n_pending;
        r_remaining <= n_remaining;
        r_out       <= n_out;
    end

    a_data_pair_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && !i_in.first && r_phase == PH_DATA_L) |=> r_out_valid)
        else $error("completed data pair produced no result");

    a_last_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && !i_in.first && r_phase == PH_DATA_L && r_remaining == 8'd1)
        |=> (r_out_valid && r_out.last && r_phase == PH_IDLE))
        else $error("final byte not flagged or decoder not idle");

    a_data_has_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA_H || r_phase == PH_DATA_L) |-> (r_remaining != 8'd0))
        else $error("data phase with zero bytes remaining");

    a_no_result_outside_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid && !(in_fire && !i_in.first && r_phase == PH_DATA_L))
        |=> !r_out_valid)
        else $error("result appeared without a completed data pair");

endmodule

// ----- tb/keyed_nibble_text_decipher_tb.sv -----
// Self-checking testbench for the keyed nibble text decipher: directed table, then random strings.
`timescale 1ns / 1ps

module keyed_nibble_text_decipher_tb;
    import kntd_pkg::*;

    typedef struct packed {
        logic [7:0] chr;
        logic       first;
        logic       checked;
        logic [7:0] plain;
        logic       last;
    } char_row_t;

    localparam int RANDOM_ITEMS = 1550;
    localparam int LONG_HOLD    = 300;

    // Key text, entry 0 in the top byte.
    localparam logic [8*256-1:0] CIPHER_KEY = {
        "0dc43e4ae9f86c17c4744ac5d94ebe8fcb8b6341916915155be5db4d2e991e20",
        "3a5510a0c4c9e4be40038b9ae1c88ffda6b04bf5ba6c74d1fc9f307d2d1f97fd",
        "682b5e46fdbaed95c526bb245cf1f25a5c39a044b7a732deebcc24153be35415",
        "843d41036c4555bc6061be4c46f94f3aa5a2bc374ecd75ab46cb2ee22ecafe28"
    };

    // Expected bytes are typed in only where the key and the pair can be read off directly.
    localparam char_row_t DIR_TABLE [0:22] = '{
        '{"a",   1'b0, 1'b0, 8'h00, 1'b0},   // idle after reset: ignored
        '{"0",   1'b1, 1'b0, 8'h00, 1'b0},   // start index 00
        '{"0",   1'b0, 1'b0, 8'h00, 1'b0},
        '{"a",   1'b0, 1'b0, 8'h00, 1'b0},   // length digit '0'
        '{"a",   1'b0, 1'b0, 8'h00, 1'b0},
        '{"f",   1'b0, 1'b0, 8'h00, 1'b0},   // length digit '2'
        '{"g",   1'b0, 1'b0, 8'h00, 1'b0},
        '{"p",   1'b0, 1'b0, 8'h00, 1'b0},   // all-ones pair
        '{"p",   1'b0, 1'b1, 8'h9C, 1'b0},
        '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0},   // extreme codes, final byte
        '{8'hFF, 1'b0, 1'b1, 8'hCA, 1'b1},
        '{"0",   1'b1, 1'b0, 8'h00, 1'b0},   // zero length string
        '{"0",   1'b0, 1'b0, 8'h00, 1'b0},
        '{"a",   1'b0, 1'b0, 8'h00, 1'b0},
        '{"a",   1'b0, 1'b0, 8'h00, 1'b0},
        '{"f",   1'b0, 1'b0, 8'h00, 1'b0},
        '{"e",   1'b0, 1'b0, 8'h00, 1'b0},
        '{"a",   1'b0, 1'b0, 8'h00, 1'b0},   // padding: ignored
        '{"F",   1'b1, 1'b0, 8'h00, 1'b0},   // upper case start index
        '{"f",   1'b0, 1'b0, 8'h00, 1'b0},
        '{"q",   1'b0, 1'b0, 8'h00, 1'b0},
        '{8'hFF, 1'b1, 1'b0, 8'h00, 1'b0},   // restart mid header
        '{"A",   1'b0, 1'b0, 8'h00, 1'b0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_in  i_in;
    logic o_out_valid;
    logic i_out_stall;
    t_out o_out;

    // Decoder state mirrored by the predictor.
    t_phase     dec_phase;
    logic [7:0] dec_key_pos;
    logic [7:0] dec_start_hi;
    logic [7:0] dec_len_hi;
    logic [3:0] dec_nibble;
    logic [7:0] dec_remaining;

    t_out      plain_expect [$];
    char_row_t char_plan [$];
    char_row_t gen_buf [$];
    logic [7:0] gen_key_pos;
    int plan_count;
    int rx_count;
    int mismatch_count;

    keyed_nibble_text_decipher uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always #4 i_clk = ~i_clk;

    function automatic logic [7:0] key_at(input logic [7:0] idx);
        return CIPHER_KEY[(255 - int'(idx)) * 8 +: 8];
    endfunction

    function automatic logic [7:0] digit_of(input logic [7:0] c);
        if (c >= "a" && c <= "f") begin
            return c - 8'h57;
        end else if (c >= "A" && c <= "F") begin
            return c - 8'h37;
        end
        return c - 8'h30;
    endfunction

    function automatic logic [7:0] digit_pair(input logic [7:0] hi, input logic [7:0] lo);
        return 8'((digit_of(hi) << 4) + digit_of(lo));
    endfunction

    function automatic logic [3:0] letter_of(input logic [7:0] c);
        return 4'(c + 8'h9F);
    endfunction

    // Complete the pair in progress and advance the key.
    function automatic logic [7:0] unmask_pair(input logic [7:0] lo);
        logic [7:0] b;
        b = {dec_nibble, letter_of(lo)} ^ key_at(dec_key_pos);
        dec_key_pos = dec_key_pos + 8'd1;
        return b;
    endfunction

    task automatic decipher_step(input t_in it, output bit emits, output t_out res);
        logic [7:0] b;
        emits = 1'b0;
        res = '0;
        if (it.first) begin
            dec_start_hi = it.cipher_char;
            dec_phase = PH_START_L;
        end else begin
            case (dec_phase)
                PH_START_L: begin
                    dec_key_pos = digit_pair(dec_start_hi, it.cipher_char);
                    dec_phase = PH_LEN0_H;
                end
                PH_LEN0_H, PH_LEN1_H, PH_DATA_H: begin
                    dec_nibble = letter_of(it.cipher_char);
                    dec_phase = t_phase'(dec_phase + 1);
                end
                PH_LEN0_L: begin
                    dec_len_hi = unmask_pair(it.cipher_char);
                    dec_phase = PH_LEN1_H;
                end
                PH_LEN1_L: begin
                    b = unmask_pair(it.cipher_char);
                    dec_remaining = digit_pair(dec_len_hi, b);
                    dec_phase = (dec_remaining == 8'd0) ? PH_IDLE : PH_DATA_H;
                end
                PH_DATA_L: begin
                    b = unmask_pair(it.cipher_char);
                    dec_remaining = dec_remaining - 8'd1;
                    emits = 1'b1;
                    res.plain_byte = b;
                    res.last = (dec_remaining == 8'd0);
                    dec_phase = (dec_remaining == 8'd0) ? PH_IDLE : PH_DATA_H;
                end
                default: dec_phase = PH_IDLE;
            endcase
        end
    endtask

    function automatic char_row_t char_row(input logic [7:0] c, input logic f);
        char_row_t r;
        r = '0;
        r.chr = c;
        r.first = f;
        return r;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) begin
            return 8'h30 + nib;
        end
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + nib - 8'd10;
    endfunction

    // Character whose offset from 'a' has the given low nibble; upper bits random now and then.
    function automatic logic [7:0] cover_char(input logic [3:0] nib);
        logic [3:0] up;
        up = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'd0;
        return 8'h61 + {up, nib};
    endfunction

    task automatic push_pair(input logic [7:0] d);
        logic [7:0] p;
        p = d ^ key_at(gen_key_pos);
        gen_buf.push_back(char_row(cover_char(p[7:4]), 1'b0));
        gen_buf.push_back(char_row(cover_char(p[3:0]), 1'b0));
        gen_key_pos = gen_key_pos + 8'd1;
    endtask

    // Encrypt one string of random plaintext; optionally cut it short.
    task automatic gen_string(input logic [7:0] len, input bit broken);
        logic [7:0] c0, c1, hi_c;
        int keep, npad;
        gen_buf.delete();
        if ($urandom_range(0, 7) == 0) begin
            c0 = 8'($urandom);
            c1 = 8'($urandom);
        end else begin
            c0 = hex_char(4'($urandom_range(0, 15)));
            c1 = hex_char(4'($urandom_range(0, 15)));
        end
        gen_buf.push_back(char_row(c0, 1'b1));
        gen_buf.push_back(char_row(c1, 1'b0));
        gen_key_pos = digit_pair(c0, c1);
        // Any code works as high length digit as long as its value has the right low nibble.
        hi_c = 8'h30 + {4'($urandom_range(0, 15)), len[7:4]};
        if ($urandom_range(0, 3) != 0 || (hi_c >= "a" && hi_c <= "f")
                || (hi_c >= "A" && hi_c <= "F")) begin
            hi_c = hex_char(len[7:4]);
        end
        push_pair(hi_c);
        push_pair(hex_char(len[3:0]));
        for (int i = 0; i < int'(len); i++) begin
            push_pair(8'($urandom));
        end
        if (broken) begin
            keep = $urandom_range(1, gen_buf.size() - 1);
            gen_buf = gen_buf[0:keep-1];
        end
        plan_count += gen_buf.size();
        char_plan = {char_plan, gen_buf};
        npad = $urandom_range(0, 3);
        repeat (npad) char_plan.push_back(char_row(8'($urandom), 1'b0));
    endtask

    initial begin : drive_chars
        char_row_t row;
        t_out pred;
        bit emits;
        bit src_burst;
        int gap, pick, nstr, nnoise;
        logic [7:0] len;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        src_burst = 1'b0;
        nstr = 0;
        plan_count = 0;
        dec_phase = PH_IDLE;
        dec_key_pos = '0;
        dec_start_hi = '0;
        dec_len_hi = '0;
        dec_nibble = '0;
        dec_remaining = '0;

        for (int i = 0; i < $size(DIR_TABLE); i++) begin
            char_plan.push_back(DIR_TABLE[i]);
        end
        while (plan_count < RANDOM_ITEMS) begin
            nstr++;
            pick = $urandom_range(0, 99);
            if (nstr == 12) begin
                len = 8'd255;
            end else if (pick < 5) begin
                len = 8'd0;
            end else if (pick < 75) begin
                len = 8'($urandom_range(1, 8));
            end else begin
                len = 8'($urandom_range(9, 40));
            end
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                gen_string(len, 1'b0);
            end else if (pick < 92) begin
                gen_string(len, 1'b1);
            end else begin
                nnoise = $urandom_range(1, 6);
                repeat (nnoise) begin
                    char_plan.push_back(char_row(8'($urandom), $urandom_range(0, 3) == 0));
                end
            end
        end

        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        while (char_plan.size() != 0) begin
            row = char_plan.pop_front();
            if ($urandom_range(0, 63) == 0) begin
                src_burst = !src_burst;
            end
            gap = src_burst ? 0 : $urandom_range(0, 13);
            repeat (gap) begin
                @(negedge i_clk);
                i_in_valid = 1'b0;
            end
            @(negedge i_clk);
            i_in_valid = 1'b1;
            i_in.cipher_char = row.chr;
            i_in.first = row.first;
            do @(posedge i_clk); while (o_in_stall);
            decipher_step(i_in, emits, pred);
            if (row.checked) begin
                pred.plain_byte = row.plain;
                pred.last = row.last;
                plain_expect.push_back(pred);
            end else if (emits) begin
                plain_expect.push_back(pred);
            end
        end
        @(negedge i_clk);
        i_in_valid = 1'b0;

        while (plain_expect.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && plain_expect.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            if (plain_expect.size() != 0) begin
                $display("%0t: %0d plaintext bytes never arrived", $time, plain_expect.size());
            end
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin : sink_pacing
        int wait_n;
        bit held;
        bit sink_burst;
        i_out_stall = 1'b0;
        held = 1'b0;
        sink_burst = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            // Hold off once for a long stretch so the input backs up.
            if (!held && rx_count >= 120) begin
                held = 1'b1;
                repeat (LONG_HOLD) begin
                    @(negedge i_clk);
                    i_out_stall = 1'b1;
                end
            end
            if ($urandom_range(0, 49) == 0) begin
                sink_burst = !sink_burst;
            end
            wait_n = sink_burst ? 0 : $urandom_range(0, 13);
            repeat (wait_n) begin
                @(negedge i_clk);
                i_out_stall = 1'b1;
            end
            @(negedge i_clk);
            i_out_stall = 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            rx_count++;
            if (plain_expect.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected transfer, expected none, got byte %h last %b",
                         $time, o_out.plain_byte, o_out.last);
            end else begin
                want = plain_expect.pop_front();
                if (o_out.plain_byte !== want.plain_byte || o_out.last !== want.last) begin
                    mismatch_count++;
                    $display("%0t: mismatch, expected byte %h last %b, got byte %h last %b",
                             $time, want.plain_byte, want.last, o_out.plain_byte, o_out.last);
                end
            end
        end
    end

    initial begin : watchdog
        rx_count = 0;
        mismatch_count = 0;
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
